// ===== sv/tbs_pkg.sv =====
`timescale 1ns / 1ps
package tbs_pkg;

  localparam int unsigned MAX_SIDE        = 256;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned COLOR_FRAC_BITS = 16;

  localparam int unsigned SIDE_W    = $clog2(MAX_SIDE) + 1;
  localparam int unsigned POS_W     = $clog2(MAX_SIDE);
  localparam int unsigned LIN_W     = 2 * POS_W;
  localparam int unsigned ADDR_W    = LIN_W + 2;
  localparam int unsigned ROW_W     = ADDR_W - 2;
  localparam int unsigned BANK_ROWS = 1 << ROW_W;
  localparam int unsigned COLOR_W   = COLOR_FRAC_BITS;
  localparam int unsigned FRAC_W    = COORD_FRAC_BITS;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned CH_W      = 3;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } store_req_t;

  typedef logic [3:0][COLOR_W-1:0] rgba_t;
  typedef logic [COLOR_W-1:0] lut_t [256];

  function automatic longint unsigned pow5_q31(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 31;
    end
    return p;
  endfunction

  // standard srgb decode curve, power done in q1.31 with a fifth-root search
  function automatic lut_t build_lut();
    lut_t            lut;
    longint unsigned c;
    longint unsigned lin;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned y;
    longint unsigned cmax;
    longint unsigned half;
    cmax = (64'd1 << COLOR_FRAC_BITS) - 64'd1;
    half = 64'd1 << 30;
    for (int i = 0; i < 256; i++) begin
      c = 64'(i);
      if (c <= 64'd10) begin
        lin = (c * 64'd20 * cmax + 64'd32946) / 64'd65892;
      end else begin
        t  = (((64'd1000 * c + 64'd14025) << 31) + 64'd134512) / 64'd269025;
        t2 = (t * t + half) >> 31;
        lo = 64'd0;
        hi = 64'd1 << 31;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (pow5_q31(mid) <= t2) lo = mid;
          else hi = mid - 64'd1;
        end
        y   = (t2 * lo + half) >> 31;
        lin = (y * cmax + half) >> 31;
      end
      if (lin > cmax) lin = cmax;
      lut[i] = lin[COLOR_W-1:0];
    end
    return lut;
  endfunction

  localparam lut_t SRGB_LUT = build_lut();

  // a + (b - a) * f, rounded half up, same as a*(1-f) + b*f
  function automatic logic [COLOR_W-1:0] lerp(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b,
                                              logic [FRAC_W-1:0] f);
    logic signed [COLOR_W:0]          d;
    logic signed [COLOR_W+FRAC_W+2:0] p;
    logic signed [COLOR_W+FRAC_W+2:0] tot;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    p   = d * $signed({1'b0, f});
    tot = $signed({3'b0, a, 1'b1, {(FRAC_W-1){1'b0}}}) + p;
    return tot[COLOR_W+FRAC_W-1:FRAC_W];
  endfunction

endpackage

// ===== sv/tbs_texel_store.sv =====
`timescale 1ns / 1ps
module tbs_texel_store (
  input  logic                clk_i,
  input  tbs_pkg::store_req_t req_i,
  output logic [31:0]         rd_word_o
);
  import tbs_pkg::*;

  logic [3:0][7:0] bank_q;
  logic [1:0]      off_q;

  // four byte banks, so four consecutive bytes from any byte address in one cycle
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]        mem [BANK_ROWS];
    logic [1:0]        lane;
    logic [ADDR_W-1:0] sum;
    logic [ROW_W-1:0]  rd_row;

    assign lane   = 2'(j) - req_i.addr[1:0];
    assign sum    = req_i.addr + {{(ADDR_W-2){1'b0}}, lane};
    assign rd_row = sum[ADDR_W-1:2];

    always_ff @(posedge clk_i) begin
      if (req_i.wr_en && req_i.addr[1:0] == 2'(j)) begin
        mem[req_i.addr[ADDR_W-1:2]] <= req_i.wdata;
      end
      if (req_i.rd_en) begin
        bank_q[j] <= mem[rd_row];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      off_q <= req_i.addr[1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_word_o[8*i +: 8] = bank_q[2'(i) + off_q];
    end
  end

endmodule

// ===== sv/texture_bilinear_sampler.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: address, byte, u, v; tuser: kind
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: red, green, blue, alpha
// apb       in   psel, penable, pwrite; out pready   paddr, pwdata; out prdata
//
// a byte write occupies the store for a single access, a sample for four texel reads (one texel per cycle
// through the four-bank texel store); the next request may enter issue while a sample's last read goes out
// a result passes stage 1, issue, the store read, decode, the blend registers and the output queue to m_axis_tvalid
// reset clears control only; the texel store has no clearing pass
// a 4-word output queue with issue credits lets samples issue while m_axis stalls until the credits run out
module texture_bilinear_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [17:0] byte_address, [25:18] byte_value, [49:26] u_coord, [73:50] v_coord
  input  logic [79:0] s_axis_tdata,
  // [0] req_type
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] red_linear, [31:16] green_linear, [47:32] blue_linear, [63:48] alpha_linear
  output logic [63:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tbs_pkg::*;

  // configuration
  logic [SIDE_W-1:0] width_q, height_q;
  logic [CH_W-1:0]   chan_q;
  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [CH_W-1:0]   ch_eff;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIDE_W'(MAX_SIDE);
      height_q <= SIDE_W'(MAX_SIDE);
      chan_q   <= CH_W'(4);
    end else if (cfg_wr) begin
      if (paddr[3:2] == REG_WIDTH)    width_q  <= pwdata[SIDE_W-1:0];
      if (paddr[3:2] == REG_HEIGHT)   height_q <= pwdata[SIDE_W-1:0];
      if (paddr[3:2] == REG_CHANNELS) chan_q   <= pwdata[CH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_WIDTH:    prdata[SIDE_W-1:0] = width_q;
      REG_HEIGHT:   prdata[SIDE_W-1:0] = height_q;
      REG_CHANNELS: prdata[CH_W-1:0]   = chan_q;
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q < SIDE_W'(2))             w_eff = SIDE_W'(2);
    else if (width_q > SIDE_W'(MAX_SIDE)) w_eff = SIDE_W'(MAX_SIDE);
    else                                  w_eff = width_q;
    if (height_q < SIDE_W'(2))             h_eff = SIDE_W'(2);
    else if (height_q > SIDE_W'(MAX_SIDE)) h_eff = SIDE_W'(MAX_SIDE);
    else                                   h_eff = height_q;
    if (chan_q == '0)            ch_eff = CH_W'(1);
    else if (chan_q > CH_W'(4))  ch_eff = CH_W'(4);
    else                         ch_eff = chan_q;
  end

  // input fields
  logic              in_sample;
  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        in_byte;
  logic [COORD_W-1:0] in_u, in_v;
  logic [POS_W-1:0]  wm2, hm2;
  logic [POS_W+FRAC_W-1:0] tx, ty;

  assign in_sample = s_axis_tuser[0];
  assign in_addr   = s_axis_tdata[17:0];
  assign in_byte   = s_axis_tdata[25:18];
  assign in_u      = s_axis_tdata[49:26];
  assign in_v      = s_axis_tdata[73:50];
  assign wm2       = POS_W'(w_eff - SIDE_W'(2));
  assign hm2       = POS_W'(h_eff - SIDE_W'(2));
  // whole parts, negative or positive, drop out with the integer bits
  assign tx        = in_u[FRAC_W-1:0] * wm2;
  assign ty        = in_v[FRAC_W-1:0] * hm2;

  // stage 1: scaled coordinates
  logic              p1_valid_q, p1_wr_q;
  logic [ADDR_W-1:0] p1_addr_q;
  logic [7:0]        p1_byte_q;
  logic [POS_W-1:0]  p1_x0_q, p1_y0_q;
  logic [FRAC_W-1:0] p1_fx_q, p1_fy_q;

  // stage 2: issue to the texel store
  logic              p2_valid_q, p2_wr_q;
  logic [ADDR_W-1:0] p2_addr_q;
  logic [7:0]        p2_byte_q;
  logic [LIN_W-1:0]  p2_lin_q;
  logic [FRAC_W-1:0] p2_fx_q, p2_fy_q;
  logic [1:0]        p2_k_q;

  logic [QPTR_W:0]   credit_q;
  logic              p2_free, p1_move, in_acc, pop;
  logic [LIN_W:0]    lin_full;

  assign p2_free = !p2_valid_q || p2_wr_q || (p2_k_q == 2'd3);
  assign p1_move = p1_valid_q && p2_free &&
                   (p1_wr_q || credit_q < (QPTR_W+1)'(QUEUE_DEPTH));
  assign s_axis_tready = !p1_valid_q || p1_move;
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign lin_full = p1_y0_q * w_eff + {{(LIN_W+1-POS_W){1'b0}}, p1_x0_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p2_k_q     <= '0;
      credit_q   <= '0;
    end else begin
      if (in_acc)       p1_valid_q <= 1'b1;
      else if (p1_move) p1_valid_q <= 1'b0;

      if (p1_move) begin
        p2_valid_q <= 1'b1;
        p2_k_q     <= '0;
      end else if (p2_valid_q && p2_free) begin
        p2_valid_q <= 1'b0;
      end else if (p2_valid_q) begin
        p2_k_q <= p2_k_q + 2'd1;
      end

      credit_q <= credit_q + (QPTR_W+1)'(p1_move && !p1_wr_q) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_wr_q   <= !in_sample;
      p1_addr_q <= in_addr;
      p1_byte_q <= in_byte;
      p1_x0_q   <= tx[POS_W+FRAC_W-1:FRAC_W];
      p1_y0_q   <= ty[POS_W+FRAC_W-1:FRAC_W];
      p1_fx_q   <= tx[FRAC_W-1:0];
      p1_fy_q   <= ty[FRAC_W-1:0];
    end
    if (p1_move) begin
      p2_wr_q   <= p1_wr_q;
      p2_addr_q <= p1_addr_q;
      p2_byte_q <= p1_byte_q;
      p2_lin_q  <= lin_full[LIN_W-1:0];
      p2_fx_q   <= p1_fx_q;
      p2_fy_q   <= p1_fy_q;
    end
  end

  // texel order: (x0,y0) (x0,y0+1) (x0+1,y0) (x0+1,y0+1)
  logic [LIN_W-1:0]  lin_k;
  logic [ADDR_W-1:0] base;
  store_req_t        store_req;
  logic [31:0]       rd_word;

  assign lin_k = p2_lin_q + {{(LIN_W-1){1'b0}}, p2_k_q[1]} +
                 (p2_k_q[0] ? {{(LIN_W-SIDE_W){1'b0}}, w_eff} : {LIN_W{1'b0}});

  always_comb begin
    unique case (ch_eff)
      CH_W'(1): base = {2'b00, lin_k};
      CH_W'(2): base = {1'b0, lin_k, 1'b0};
      CH_W'(3): base = {2'b00, lin_k} + {1'b0, lin_k, 1'b0};
      default:  base = {lin_k, 2'b00};
    endcase
    store_req.wr_en = p2_valid_q & p2_wr_q;
    store_req.rd_en = p2_valid_q & !p2_wr_q;
    store_req.addr  = p2_wr_q ? p2_addr_q : base;
    store_req.wdata = p2_byte_q;
  end

  tbs_texel_store u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_word_o (rd_word)
  );

  // stage 3: read data back
  logic              m_valid_q;
  logic [1:0]        m_k_q;
  logic [FRAC_W-1:0] m_fx_q, m_fy_q;

  // stage 4: decoded texel
  logic              d_valid_q;
  logic [1:0]        d_k_q;
  logic [FRAC_W-1:0] d_fx_q, d_fy_q;
  rgba_t             d_pix_q;

  // column blend and final blend
  rgba_t             prev_q, c0_q, e_c0_q, e_c1_q;
  logic              e_valid_q;
  logic [FRAC_W-1:0] e_fx_q;

  logic [3:0][7:0]   chan;
  rgba_t             dec, col, fin;

  always_comb begin
    chan[0] = rd_word[7:0];
    chan[3] = 8'hFF;
    unique case (ch_eff)
      CH_W'(1): begin
        chan[1] = rd_word[7:0];
        chan[2] = rd_word[7:0];
      end
      CH_W'(2): begin
        chan[1] = rd_word[15:8];
        chan[2] = 8'h00;
      end
      CH_W'(3): begin
        chan[1] = rd_word[15:8];
        chan[2] = rd_word[23:16];
      end
      default: begin
        chan[1] = rd_word[15:8];
        chan[2] = rd_word[23:16];
        chan[3] = rd_word[31:24];
      end
    endcase
    for (int c = 0; c < 4; c++) begin
      dec[c] = SRGB_LUT[chan[c]];
      col[c] = lerp(prev_q[c], d_pix_q[c], d_fy_q);
      fin[c] = lerp(e_c0_q[c], e_c1_q[c], e_fx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      m_valid_q <= store_req.rd_en;
      d_valid_q <= m_valid_q;
      e_valid_q <= d_valid_q && d_k_q == 2'd3;
    end
  end

  always_ff @(posedge clk_i) begin
    m_k_q  <= p2_k_q;
    m_fx_q <= p2_fx_q;
    m_fy_q <= p2_fy_q;
    if (m_valid_q) begin
      d_k_q   <= m_k_q;
      d_fx_q  <= m_fx_q;
      d_fy_q  <= m_fy_q;
      d_pix_q <= dec;
    end
    if (d_valid_q) begin
      if (!d_k_q[0]) prev_q <= d_pix_q;
      if (d_k_q == 2'd1) c0_q <= col;
      if (d_k_q == 2'd3) begin
        e_c0_q <= c0_q;
        e_c1_q <= col;
        e_fx_q <= d_fx_q;
      end
    end
  end

  // output queue, space reserved by the issue credit
  logic [63:0]       q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] q_wr_q, q_rd_q;
  logic [QPTR_W:0]   q_cnt_q;

  assign m_axis_tvalid = q_cnt_q != '0;
  assign m_axis_tdata  = q_mem[q_rd_q];
  assign pop           = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (e_valid_q) q_wr_q <= q_wr_q + QPTR_W'(1);
      if (pop)       q_rd_q <= q_rd_q + QPTR_W'(1);
      q_cnt_q <= q_cnt_q + (QPTR_W+1)'(e_valid_q) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_valid_q) begin
      q_mem[q_wr_q] <= fin;
    end
  end

endmodule

// ===== sv/tbs_checker.sv =====
`timescale 1ns / 1ps
module tbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import tbs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[3:2] == REG_WIDTH |=>
    paddr[3:2] != REG_WIDTH || prdata[8:0] == $past(pwdata[8:0]))
    else $error("width register readback mismatch");

  a_chan_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[3:2] == REG_CHANNELS |=>
    paddr[3:2] != REG_CHANNELS || prdata[31:0] == {29'b0, $past(pwdata[2:0])})
    else $error("channel register readback mismatch");

endmodule

bind texture_bilinear_sampler tbs_checker u_tbs_checker (.*);
